### rtl/core/cdip_pkg.sv
// ----------------------------------------------------------------------------
// cdip_pkg
// Shared types and constants for the checked decimal integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cdip_pkg;

    localparam int COUNT_SAT_DEFAULT = 1023;

    localparam int VALUE_W   = 32;
    localparam int ACC_W     = 34;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CHAR_W    = 8;
    localparam int DEPTH_DEF = 2;

    localparam int MAX_DIGITS = 10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [ACC_W-1:0] POS_LIMIT = 34'd2147483647;
    localparam logic [ACC_W-1:0] NEG_LIMIT = 34'd2147483648;

    localparam logic [VALUE_W-1:0] LOWER_RESET = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] UPPER_RESET = 32'h7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER       = 2'd0,
        CFG_UPPER       = 2'd1,
        CFG_CHECK_LOWER = 2'd2,
        CFG_CHECK_UPPER = 2'd3
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_LEADING_ZERO = 3'd1,
        ST_TOO_LONG     = 3'd2,
        ST_BAD_CHAR     = 3'd3,
        ST_OVERFLOW     = 3'd4,
        ST_OUT_OF_RANGE = 3'd5,
        ST_INVERTED     = 3'd6
    } status_t;

    // Token summary handed from front to back (count travels alongside).
    typedef struct packed {
        logic             neg;
        logic             first_zero;
        logic [POS_W-1:0] bad_pos;
        logic [ACC_W-1:0] acc;
    } tok_t;

    typedef struct packed {
        logic [VALUE_W-1:0] lower;
        logic [VALUE_W-1:0] upper;
        logic               check_lower;
        logic               check_upper;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/core/cdip_if.sv
// ----------------------------------------------------------------------------
// cdip_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdip_in_if
    import cdip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface cdip_out_if
    import cdip_pkg::*;
#(
    parameter int DETAIL_W = $clog2(COUNT_SAT_DEFAULT + 1)
);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DETAIL_W-1:0] detail;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output status, output detail, output value, input ready);
    modport sink   (input valid, input status, input detail, input value, output ready);
endinterface

`default_nettype wire

### rtl/core/cdip_front.sv
// ----------------------------------------------------------------------------
// cdip_front
// Takes one character per cycle unless stalled, tracks sign, count, first
// bad position and decimal accumulator; pushes a token summary on is_last.
// ----------------------------------------------------------------------------
`default_nettype none

module cdip_front
    import cdip_pkg::*;
#(
    parameter int COUNT_SATURATE = COUNT_SAT_DEFAULT,
    parameter int CNT_W          = $clog2(COUNT_SATURATE + 1)
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    cdip_in_if.sink          in_ch,
    output logic             push_valid,
    input  wire logic        push_ready,
    output logic [CNT_W-1:0] push_count,
    output tok_t             push_tok
);

    logic             start_reg, start_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fz_reg, fz_next;
    logic [POS_W-1:0] bad_reg, bad_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic             accept;
    logic             is_digit;
    logic [3:0]       digit_val;

    assign accept     = in_ch.valid && push_ready;
    assign in_ch.ready = push_ready;
    assign is_digit   = (in_ch.char_code >= CHAR_ZERO) && (in_ch.char_code <= CHAR_NINE);
    // low nibble of '0'..'9' is the digit value
    assign digit_val  = in_ch.char_code[3:0];

    // Token state after taking the current character.
    always_comb
    begin
        start_next = 1'b0;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        fz_next    = fz_reg;
        bad_next   = bad_reg;
        acc_next   = acc_reg;
        if (start_reg && in_ch.char_code == CHAR_MINUS)
        begin
            neg_next = 1'b1;
        end
        else
        begin
            if (cnt_reg < CNT_W'(COUNT_SATURATE))
                cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_next == CNT_W'(1) && in_ch.char_code == CHAR_ZERO)
                fz_next = 1'b1;
            if (cnt_next <= CNT_W'(MAX_DIGITS))
            begin
                if (is_digit)
                    acc_next = (acc_reg << 3) + (acc_reg << 1)
                               + ACC_W'(digit_val);
                else if (bad_reg == '0)
                    bad_next = cnt_next[POS_W-1:0];
            end
        end
    end

    assign push_valid          = in_ch.valid && in_ch.is_last;
    assign push_count          = cnt_next;
    assign push_tok.neg        = neg_next;
    assign push_tok.first_zero = fz_next;
    assign push_tok.bad_pos    = bad_next;
    assign push_tok.acc        = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
            fz_reg    <= 1'b0;
            bad_reg   <= '0;
            acc_reg   <= '0;
        end
        else if (accept)
        begin
            if (in_ch.is_last)
            begin
                start_reg <= 1'b1;
                neg_reg   <= 1'b0;
                cnt_reg   <= '0;
                fz_reg    <= 1'b0;
                bad_reg   <= '0;
                acc_reg   <= '0;
            end
            else
            begin
                start_reg <= start_next;
                neg_reg   <= neg_next;
                cnt_reg   <= cnt_next;
                fz_reg    <= fz_next;
                bad_reg   <= bad_next;
                acc_reg   <= acc_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/cdip_queue.sv
// ----------------------------------------------------------------------------
// cdip_queue
// Small FIFO of token summaries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cdip_queue
    import cdip_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = DEPTH_DEF
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

### rtl/core/cdip_back.sv
// ----------------------------------------------------------------------------
// cdip_back
// Checks a finished token in priority order, keeps the stored value and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdip_back
    import cdip_pkg::*;
#(
    parameter int CNT_W = $clog2(COUNT_SAT_DEFAULT + 1)
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             q_empty,
    input  wire logic [CNT_W-1:0] q_count,
    input  wire tok_t             q_tok,
    output logic                  q_pop,
    cdip_out_if.source            out_ch
);

    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [CNT_W-1:0]    detail_reg, detail_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  stored_reg;

    logic [VALUE_W:0]    mag;
    logic [VALUE_W:0]    val;
    logic [VALUE_W:0]    lo_ext, hi_ext;
    logic [ACC_W-1:0]    limit;

    assign q_pop  = !q_empty && (!out_valid_reg || out_ch.ready);
    assign mag    = {1'b0, q_tok.acc[VALUE_W-1:0]};
    assign val    = q_tok.neg ? ((VALUE_W+1)'(0) - mag) : mag;
    assign lo_ext = {cfg.lower[VALUE_W-1], cfg.lower};
    assign hi_ext = {cfg.upper[VALUE_W-1], cfg.upper};
    assign limit  = q_tok.neg ? NEG_LIMIT : POS_LIMIT;

    always_comb
    begin
        status_next = ST_OK;
        detail_next = '0;
        priority if (cfg.check_lower && cfg.check_upper
                     && $signed(cfg.lower) > $signed(cfg.upper))
            status_next = ST_INVERTED;
        else if (q_tok.first_zero && q_count >= CNT_W'(2))
            status_next = ST_LEADING_ZERO;
        else if (q_count > CNT_W'(MAX_DIGITS))
        begin
            status_next = ST_TOO_LONG;
            detail_next = q_count;
        end
        else if (q_tok.bad_pos != '0)
        begin
            status_next = ST_BAD_CHAR;
            detail_next = CNT_W'(q_tok.bad_pos);
        end
        else if (q_count == CNT_W'(MAX_DIGITS) && q_tok.acc > limit)
            status_next = ST_OVERFLOW;
        else if ((cfg.check_lower && $signed(val) < $signed(lo_ext))
                 || (cfg.check_upper && $signed(val) > $signed(hi_ext)))
            status_next = ST_OUT_OF_RANGE;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            stored_reg    <= '0;
        end
        else
        begin
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (q_pop && status_next == ST_OK)
                stored_reg <= val[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            detail_reg <= detail_next;
            value_reg  <= (status_next == ST_OK) ? val[VALUE_W-1:0] : stored_reg;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = status_reg;
    assign out_ch.detail = detail_reg;
    assign out_ch.value  = value_reg;

    // A shown result always matches the stored value.
    a_value_matches_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> value_reg == stored_reg)
        else $error("result value differs from stored value");

    a_detail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_TOO_LONG && status_reg != ST_BAD_CHAR)
        |-> detail_reg == '0)
        else $error("detail set for a status without detail");

    a_bad_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_BAD_CHAR)
        |-> (detail_reg >= CNT_W'(1) && detail_reg <= CNT_W'(MAX_DIGITS)))
        else $error("bad character position out of range");

endmodule

`default_nettype wire

### rtl/core/checked_decimal_int_parser.sv
// ----------------------------------------------------------------------------
// checked_decimal_int_parser
// Parses a decimal token (optional minus, digits) into a checked int32.
//
// Usage:
//   in_ch   valid/ready channel, one character per item, is_last on the final
//           character of a token. Accepts one item per cycle unless stalled.
//   out_ch  valid/ready channel, one result (status, detail, value) per
//           token, issued for the item carrying is_last.
//   cfg_*   write port for lower_bound, upper_bound, check_lower,
//           check_upper; write only while no token is in flight.
//   Path: a token summary enters the queue at the edge that accepts its
//   last character and is checked into the output register when the back
//   pops it from the queue.
//   Throughput: one character per cycle; back to back one-character tokens
//   give one result per cycle, while out_ch is ready and the queue has room.
//   Stall: when out_ch is held, results wait in the output register and the
//   two-entry summary queue; in_ch.ready drops only when the queue is full.
//   Reset: token state cleared, stored value 0, bounds to the full int32
//   range with both checks off.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_decimal_int_parser
    import cdip_pkg::*;
#(
    parameter int COUNT_SATURATE = COUNT_SAT_DEFAULT
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    cdip_in_if.sink                   in_ch,
    cdip_out_if.source                out_ch,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VALUE_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(COUNT_SATURATE + 1);
    localparam int Q_W   = CNT_W + $bits(tok_t);

    cfg_t             cfg_reg;
    logic             push_valid;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [CNT_W-1:0] push_count;
    tok_t             push_tok;
    logic [Q_W-1:0]   q_out;
    logic [CNT_W-1:0] q_count;
    tok_t             q_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower       <= LOWER_RESET;
            cfg_reg.upper       <= UPPER_RESET;
            cfg_reg.check_lower <= 1'b0;
            cfg_reg.check_upper <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOWER:       cfg_reg.lower       <= cfg_data;
                CFG_UPPER:       cfg_reg.upper       <= cfg_data;
                CFG_CHECK_LOWER: cfg_reg.check_lower <= cfg_data[0];
                CFG_CHECK_UPPER: cfg_reg.check_upper <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cdip_front #(
        .COUNT_SATURATE (COUNT_SATURATE),
        .CNT_W          (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (!q_full),
        .push_count (push_count),
        .push_tok   (push_tok)
    );

    cdip_queue #(
        .WIDTH (Q_W),
        .DEPTH (DEPTH_DEF)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid && !q_full),
        .push_data ({push_count, push_tok}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign q_count = q_out[Q_W-1 -: CNT_W];
    assign q_tok   = tok_t'(q_out[$bits(tok_t)-1:0]);

    cdip_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_count (q_count),
        .q_tok   (q_tok),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for checked_decimal_int_parser. Tokens are sent one
// character per item on a valid/ready channel; each accepted item goes
// through a local parser model, and every result item is compared field by
// field against the oldest predicted result. Bound registers are changed
// between phases while the block is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    import cdip_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 80;
    localparam int RANDOM_CHARS  = 800;
    localparam int QUIET_CHARS   = 620;
    localparam int SETTLE_CYCLES = 4;
    localparam int N_BOUNDARY    = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } char_item_t;

    typedef struct packed {
        status_t            status;
        logic [9:0]         detail;
        logic [VALUE_W-1:0] value;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VALUE_W-1:0]   cfg_data;

    cdip_in_if  in_ch ();
    cdip_out_if out_ch ();

    checked_decimal_int_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Parser model state
    logic                  tok_at_start  = 1'b1;
    logic                  tok_neg       = 1'b0;
    logic [9:0]            tok_count     = '0;
    logic                  tok_lead_zero = 1'b0;
    logic [POS_W-1:0]      tok_bad_pos   = '0;
    logic [ACC_W-1:0]      tok_acc       = '0;
    logic [VALUE_W-1:0]    held_value    = '0;
    logic signed [VALUE_W-1:0] bound_lo  = LOWER_RESET;
    logic signed [VALUE_W-1:0] bound_hi  = UPPER_RESET;
    logic                  bound_lo_on   = 1'b0;
    logic                  bound_hi_on   = 1'b0;

    char_item_t    char_queue[$];
    parse_result_t expected_results[$];
    logic [CHAR_W-1:0] tok_buf[$];

    string boundary_tokens [N_BOUNDARY] = '{
        "2147483647", "2147483648", "-2147483648", "-2147483649", "4294967295",
        "9999999999", "-0", "-", "1000000000", "-2147483647"
    };

    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  chars_queued = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  rx_long_req  = 0;
    int  rx_long_seen = 0;
    int  tx_gap       = 0;
    int  rx_hold      = 0;
    bit  tx_skip_roll = 0;
    bit  rx_skip_roll = 0;
    bit  char_taken   = 0;

    // One character into the model; on the last one, predict the result.
    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic is_last);
        logic              is_digit;
        longint            v;
        parse_result_t     r;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        if (tok_at_start && c == CHAR_MINUS) begin
            tok_at_start = 1'b0;
            tok_neg = 1'b1;
        end
        else begin
            tok_at_start = 1'b0;
            if (tok_count < COUNT_SAT_DEFAULT)
                tok_count = tok_count + 1'b1;
            if (tok_count == 1 && c == CHAR_ZERO)
                tok_lead_zero = 1'b1;
            if (tok_count <= MAX_DIGITS) begin
                if (is_digit)
                    tok_acc = tok_acc * 10 + (c - CHAR_ZERO);
                else if (tok_bad_pos == 0)
                    tok_bad_pos = tok_count[POS_W-1:0];
            end
        end
        if (is_last) begin
            r.status = ST_OK;
            r.detail = '0;
            v = tok_neg ? -longint'(tok_acc) : longint'(tok_acc);
            if (bound_lo_on && bound_hi_on && bound_lo > bound_hi)
                r.status = ST_INVERTED;
            else if (tok_lead_zero && tok_count >= 2)
                r.status = ST_LEADING_ZERO;
            else if (tok_count > MAX_DIGITS) begin
                r.status = ST_TOO_LONG;
                r.detail = tok_count;
            end
            else if (tok_bad_pos != 0) begin
                r.status = ST_BAD_CHAR;
                r.detail = 10'(tok_bad_pos);
            end
            else if (tok_count == MAX_DIGITS && tok_acc > (tok_neg ? NEG_LIMIT : POS_LIMIT))
                r.status = ST_OVERFLOW;
            else if ((bound_lo_on && v < bound_lo) || (bound_hi_on && v > bound_hi))
                r.status = ST_OUT_OF_RANGE;
            else
                held_value = v[VALUE_W-1:0];
            r.value = held_value;
            expected_results.push_back(r);
            tok_at_start = 1'b1;
            tok_neg = 1'b0;
            tok_count = '0;
            tok_lead_zero = 1'b0;
            tok_bad_pos = '0;
            tok_acc = '0;
        end
    endtask

    // ---------------- character driver ----------------
    always @(posedge clk)
    begin
        char_taken = rst_n && in_ch.valid && in_ch.ready;
        if (char_taken) begin
            parse_char(in_ch.char_code, in_ch.is_last);
            void'(char_queue.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !char_taken) begin
            // item still on offer: hold it
        end
        else if (tx_gap > 0) begin
            tx_gap = tx_gap - 1;
            tx_skip_roll = 1;
            in_ch.valid <= 1'b0;
        end
        else if (char_queue.size() > 0) begin
            if (!tx_skip_roll && $urandom_range(0, 99) < tx_idle_pct) begin
                tx_gap = $urandom_range(0, 10);
                in_ch.valid <= 1'b0;
            end
            else begin
                tx_skip_roll = 0;
                in_ch.valid     <= 1'b1;
                in_ch.char_code <= char_queue[0].code;
                in_ch.is_last   <= char_queue[0].is_last;
            end
        end
        else
            in_ch.valid <= 1'b0;
    end

    // ---------------- result receiver ----------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (rx_long_req != rx_long_seen) begin
            rx_long_seen = rx_long_req;
            rx_hold = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end
        else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            rx_skip_roll = 1;
            out_ch.ready <= 1'b0;
        end
        else if (!rx_skip_roll && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_hold = $urandom_range(0, 10);
            out_ch.ready <= 1'b0;
        end
        else begin
            rx_skip_roll = 0;
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        parse_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d detail %0d value %0d",
                       out_ch.status, out_ch.detail, $signed(out_ch.value));
                fail_count++;
            end
            else begin
                want = expected_results.pop_front();
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_ch.status);
                    fail_count++;
                end
                if (out_ch.detail !== want.detail) begin
                    $error("detail: expected %0d, got %0d", want.detail, out_ch.detail);
                    fail_count++;
                end
                if (out_ch.value !== want.value) begin
                    $error("value: expected %0d, got %0d",
                           $signed(want.value), $signed(out_ch.value));
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic write_reg(input cfg_idx_t idx, input logic [VALUE_W-1:0] data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        case (idx)
            CFG_LOWER:       bound_lo    = data;
            CFG_UPPER:       bound_hi    = data;
            CFG_CHECK_LOWER: bound_lo_on = data[0];
            CFG_CHECK_UPPER: bound_hi_on = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    // Enable registers get random upper bits; only bit 0 counts.
    task automatic set_limits(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                              input bit lo_on, input bit hi_on);
        write_reg(CFG_LOWER, lo);
        write_reg(CFG_UPPER, hi);
        write_reg(CFG_CHECK_LOWER, ($urandom() & 32'hFFFF_FFFE) | lo_on);
        write_reg(CFG_CHECK_UPPER, ($urandom() & 32'hFFFF_FFFE) | hi_on);
    endtask

    task automatic pick_limits();
        int          lo, hi;
        logic [31:0] raw;
        case ($urandom_range(0, 9))
            0: set_limits(LOWER_RESET, UPPER_RESET, 1'b1, 1'b1);
            1: begin
                if ($urandom_range(0, 1) == 0)
                    set_limits(UPPER_RESET, LOWER_RESET, 1'b1, 1'b1);
                else begin
                    lo = $urandom_range(0, 5000);
                    set_limits(lo, lo - int'($urandom_range(1, 1000)), 1'b1, 1'b1);
                end
            end
            2, 3, 4: begin
                lo = -int'($urandom_range(0, 5000));
                hi = $urandom_range(0, 5000);
                set_limits(lo, hi, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            5: set_limits($urandom(), $urandom(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            6: set_limits($urandom(), $urandom(), 1'b0, 1'b0);
            7: begin
                raw = $urandom_range(0, 200) - 100;
                set_limits(raw, raw, 1'b1, 1'b1);
            end
            8: set_limits(UPPER_RESET, UPPER_RESET, 1'b1, 1'b0);
            default: set_limits(LOWER_RESET, LOWER_RESET, 1'b0, 1'b1);
        endcase
    endtask

    task automatic emit_token();
        int         i;
        char_item_t item;
        for (i = 0; i < tok_buf.size(); i++) begin
            item.code    = tok_buf[i];
            item.is_last = (i == tok_buf.size() - 1);
            char_queue.push_back(item);
        end
        chars_queued += tok_buf.size();
        tok_buf.delete();
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            tok_buf.push_back(s[i]);
    endtask

    task automatic add_text(input string s);
        put_text(s);
        emit_token();
    endtask

    task automatic add_byte(input logic [CHAR_W-1:0] c);
        tok_buf.push_back(c);
        emit_token();
    endtask

    // n digits, first one nonzero when n > 1
    task automatic put_number(input int n, input bit neg);
        int i;
        if (neg)
            tok_buf.push_back(CHAR_MINUS);
        for (i = 0; i < n; i++) begin
            if (i == 0 && n > 1)
                tok_buf.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
            else
                tok_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    function automatic logic [CHAR_W-1:0] rand_non_digit();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(0, 7))
            0: c = CHAR_MINUS;
            1: c = " ";
            2: c = 8'h00;
            default: begin
                c = 8'($urandom_range(0, 255));
                while (c >= CHAR_ZERO && c <= CHAR_NINE)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    task automatic add_random_token();
        int pick, n, i, k, base;
        bit neg;
        pick = $urandom_range(0, 99);
        neg  = ($urandom_range(0, 9) < 3);
        base = neg ? 1 : 0;
        if (pick < 50) begin
            k = $urandom_range(0, 19);
            n = (k < 12) ? $urandom_range(1, 4) : (k < 17) ? $urandom_range(5, 9) : 10;
            put_number(n, neg);
        end
        else if (pick < 58) begin
            // straddles the int32 limit
            if (neg)
                tok_buf.push_back(CHAR_MINUS);
            put_text("214748364");
            tok_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick < 63)
            put_text(boundary_tokens[$urandom_range(0, N_BOUNDARY - 1)]);
        else if (pick < 71) begin
            if (neg)
                tok_buf.push_back(CHAR_MINUS);
            tok_buf.push_back(CHAR_ZERO);
            for (i = 0; i < $urandom_range(1, 5); i++)
                tok_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick < 79) begin
            n = $urandom_range(11, 24);
            put_number(n, neg);
            if ($urandom_range(0, 3) == 0)
                tok_buf[base + $urandom_range(0, n - 1)] = rand_non_digit();
        end
        else if (pick < 93) begin
            n = $urandom_range(1, 10);
            put_number(n, neg);
            k = $urandom_range(1, 2);
            for (i = 0; i < k; i++)
                tok_buf[base + $urandom_range(0, n - 1)] = rand_non_digit();
        end
        else begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                tok_buf.push_back(8'($urandom_range(0, 255)));
        end
        emit_token();
    endtask

    task automatic wait_idle();
        while (char_queue.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------- test sequence ----------------
    initial
    begin
        int i, n, phase_no, random_start;
        in_ch.valid     = 1'b0;
        in_ch.char_code = '0;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = CFG_LOWER;
        cfg_data        = '0;
        rst_n           = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset bounds: lone minus, minus zero, leading zero, stray bytes
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        add_text("-");
        add_text("-0");
        add_text("0");
        add_text("7");
        add_text("07");
        add_text("3-");
        add_text("--");
        add_byte(" ");
        add_byte(8'h00);
        add_byte(8'hFF);
        wait_idle();

        // full int32 window with both checks on
        set_limits(LOWER_RESET, UPPER_RESET, 1'b1, 1'b1);
        add_text("2147483647");
        add_text("-2147483648");
        wait_idle();

        random_start = chars_queued;
        phase_no = 0;
        while (chars_queued - random_start < QUIET_CHARS) begin
            pick_limits();
            tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            @(posedge clk);
            if (phase_no == 0) begin
                // receiver stalls long while short tokens keep coming
                tx_idle_pct = 0;
                rx_long_req++;
                for (i = 0; i < 30; i++)
                    add_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            n = $urandom_range(10, 30);
            for (i = 0; i < n; i++)
                add_random_token();
            wait_idle();
            phase_no++;
        end

        // closing stretch with no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        do begin
            pick_limits();
            n = $urandom_range(10, 30);
            for (i = 0; i < n; i++)
                add_random_token();
            wait_idle();
        end while (chars_queued - random_start < RANDOM_CHARS);

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/core/cdip_pkg.sv
rtl/core/cdip_if.sv
rtl/core/cdip_front.sv
rtl/core/cdip_queue.sv
rtl/core/cdip_back.sv
rtl/core/checked_decimal_int_parser.sv
tb/tb.sv
